// ----- hw/rtl/sha256_pkg.sv -----
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  // Sequencer states of the hasher.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_INIT,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  // Controls for the message schedule window.
  typedef struct packed {
    logic       wr;
    logic [5:0] idx;
    logic [7:0] val;
    logic       shift;
  } sched_ctrl_t;

  // Controls for the round datapath.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       fold;
    logic       restart;
    logic [5:0] rnd;
  } round_ctrl_t;

  localparam int unsigned NumRounds  = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadMark    = 8'h80;

  // Initial hash values, word 0 in the lowest slot.
  localparam hash_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t small_sigma0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

// ----- hw/rtl/sha256_sched.sv -----
// Sixteen-word window that first collects the block bytes big-endian and
// then rolls forward as the message schedule, one word per round.
module sha256_sched (
  input  logic                      clk,
  input  sha256_pkg::sched_ctrl_t   ctrl,
  output sha256_pkg::word_t         w_cur
);

  logic [15:0][31:0] win;
  sha256_pkg::word_t w_new;

  assign w_new = sha256_pkg::small_sigma1(win[14]) + win[9] +
                 sha256_pkg::small_sigma0(win[1]) + win[0];
  assign w_cur = win[0];

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      win[ctrl.idx[5:2]][{~ctrl.idx[1:0], 3'b000} +: 8] <= ctrl.val;
    end else if (ctrl.shift) begin
      win <= {w_new, win[15:1]};
    end
  end

endmodule

// ----- hw/rtl/sha256_round.sv -----
// Working variables a..h, one compression round per cycle while ctrl.step is
// high, and the chained hash words that absorb each block.
module sha256_round (
  input  logic                      clk,
  input  logic                      rst,
  input  sha256_pkg::round_ctrl_t   ctrl,
  input  sha256_pkg::word_t         w_cur,
  output sha256_pkg::hash_t         hash
);

  sha256_pkg::hash_t v;
  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;

  // v[0] is a, v[7] is h.
  assign t1 = v[7] + sha256_pkg::big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
              sha256_pkg::RoundK[ctrl.rnd] + w_cur;
  assign t2 = sha256_pkg::big_sigma0(v[0]) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v <= hash;
    end else if (ctrl.step) begin
      v <= {v[6], v[5], v[4], v[3] + t1, v[2], v[1], v[0], t1 + t2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      hash <= sha256_pkg::HashInit;
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + v[i];
      end
    end
  end

endmodule

// ----- hw/rtl/sha256_stream_hasher_core.sv -----
// SHA-256 over a byte stream. Each input item carries one message byte in
// s_tdata, with s_tuser high when that byte belongs to the message, and
// s_tlast high on the item that ends the message; an item with s_tuser low
// and s_tlast high ends a message without adding a byte, which also allows
// the empty message. Once the message ends, the block appends the standard
// padding and the 64-bit bit length (modulo 2^64) and then presents the
// eight digest words as output items, word 0 (most significant) first, with
// m_tlast on the eighth; after that it is ready for the next message.
// Timing: a byte that neither completes a block nor ends the message leaves
// s_tready high. The 64th byte of a block starts a compression (a load, 64
// rounds through the single round unit, a fold into the hash), during which
// s_tready is low, so a long message stalls its input once per block. At the
// end of a message, padding is written one byte per cycle through the same
// byte path, followed by one or two compressions and eight output items. No
// input is taken while the digest words are being delivered.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_tlast    // last_word
);

  sha256_pkg::state_t      state;
  sha256_pkg::state_t      state_next;
  sha256_pkg::sched_ctrl_t sched_ctrl;
  sha256_pkg::round_ctrl_t round_ctrl;
  sha256_pkg::hash_t       hash;
  sha256_pkg::word_t       w_cur;

  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  logic        finishing;    // message ended, digest still to come
  logic        pad_started;  // the 0x80 marker has been written
  logic        len_block;    // the current block carries the length field
  logic        pad_done;     // the last padded block has been queued

  logic        in_acc;
  logic        out_acc;
  logic        msg_byte;
  logic        restart;
  logic [7:0]  pad_byte;

  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;
  assign msg_byte = in_acc && s_tuser;
  assign restart  = out_acc && (out_idx == 3'd7);

  // Padding byte: marker first, then zeros, with the big-endian bit count in
  // the last eight places of the block that carries it.
  always_comb begin
    if (!pad_started) begin
      pad_byte = sha256_pkg::PadMark;
    end else if (len_block && (fill >= 6'(sha256_pkg::LenPos))) begin
      pad_byte = msg_bits[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser && (fill == 6'(sha256_pkg::BlockBytes - 1))) begin
            state_next = sha256_pkg::ST_INIT;
          end else if (s_tlast) begin
            state_next = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (fill == 6'(sha256_pkg::BlockBytes - 1)) begin
          state_next = sha256_pkg::ST_INIT;
        end
      end
      sha256_pkg::ST_INIT: begin
        state_next = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd == 6'(sha256_pkg::NumRounds - 1)) begin
          state_next = sha256_pkg::ST_FOLD;
        end
      end
      sha256_pkg::ST_FOLD: begin
        if (!finishing) begin
          state_next = sha256_pkg::ST_IDLE;
        end else if (pad_done) begin
          state_next = sha256_pkg::ST_OUT;
        end else begin
          state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (restart) begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // Output and datapath control decode. The strobes here are built from the
  // raw handshake inputs, since the state alone already fixes which side is
  // ready.
  always_comb begin
    s_tready         = 1'b0;
    m_tvalid         = 1'b0;
    sched_ctrl.wr    = 1'b0;
    sched_ctrl.idx   = fill;
    sched_ctrl.val   = pad_byte;
    sched_ctrl.shift = 1'b0;
    round_ctrl.load  = 1'b0;
    round_ctrl.step  = 1'b0;
    round_ctrl.fold  = 1'b0;
    round_ctrl.restart = 1'b0;
    round_ctrl.rnd   = rnd;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        s_tready       = 1'b1;
        sched_ctrl.wr  = s_tvalid && s_tuser;
        sched_ctrl.val = s_tdata;
      end
      sha256_pkg::ST_PAD: begin
        sched_ctrl.wr = 1'b1;
      end
      sha256_pkg::ST_INIT: begin
        round_ctrl.load = 1'b1;
      end
      sha256_pkg::ST_ROUND: begin
        round_ctrl.step  = 1'b1;
        sched_ctrl.shift = 1'b1;
      end
      sha256_pkg::ST_FOLD: begin
        round_ctrl.fold = 1'b1;
      end
      sha256_pkg::ST_OUT: begin
        m_tvalid           = 1'b1;
        round_ctrl.restart = m_tready && (out_idx == 3'd7);
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {5'b00000, out_idx, hash[out_idx]};
  assign m_tlast = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      fill        <= '0;
      msg_bits    <= '0;
      finishing   <= 1'b0;
      pad_started <= 1'b0;
      len_block   <= 1'b0;
      pad_done    <= 1'b0;
    end else begin
      if (sched_ctrl.wr) begin
        fill <= fill + 6'd1;
      end
      if (msg_byte) begin
        msg_bits <= msg_bits + 64'd8;
      end
      if (in_acc && s_tlast) begin
        finishing <= 1'b1;
      end
      if (state == sha256_pkg::ST_PAD) begin
        pad_started <= 1'b1;
        if (fill == 6'(sha256_pkg::BlockBytes - 1)) begin
          if (len_block && pad_started) begin
            pad_done <= 1'b1;
          end else begin
            len_block <= 1'b1;
          end
        end else if (!pad_started) begin
          len_block <= (fill < 6'(sha256_pkg::LenPos));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd     <= '0;
      out_idx <= '0;
    end else begin
      if (state == sha256_pkg::ST_INIT) begin
        rnd <= '0;
      end else if (state == sha256_pkg::ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  sha256_sched u_sched (
    .clk   (clk),
    .ctrl  (sched_ctrl),
    .w_cur (w_cur)
  );

  sha256_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (round_ctrl),
    .w_cur (w_cur),
    .hash  (hash)
  );

endmodule

// ----- tb/sha256_digest_checker.sv -----
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          words_due
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]  chain [8];
  logic [7:0]   block_buf [64];
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  digest_word_t digest_due [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_chain();
    for (int i = 0; i < 8; i++) chain[i] = StartHash[i];
    fill = '0;
    bit_count = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        s1 = ror(w[(t-2)&15], 17) ^ ror(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
        s0 = ror(w[(t-15)&15], 7) ^ ror(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
        w[t&15] = s1 + w[(t-7)&15] + s0 + w[t&15];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t&15];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    block_buf[fill] = b;
    fill = fill + 6'd1;
    bit_count = bit_count + 64'd8;
    if (fill == 6'd0) compress_block();
  endfunction

  // Pads the open block, folds in the length and queues the eight words.
  function automatic void finish_message();
    digest_word_t item;
    int pos;
    pos = fill;
    block_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_buf[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) block_buf[56+i] = bit_count[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      item.word  = chain[i];
      item.index = 3'(i);
      item.last  = (i == 7);
      digest_due.push_back(item);
    end
    restart_chain();
  endfunction

  always @(posedge clk) begin
    digest_word_t want;
    if (rst) begin
      restart_chain();
      digest_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser) absorb_byte(s_tdata);
        if (s_tlast) finish_message();
      end
      if (m_tvalid && m_tready) begin
        if (digest_due.size() == 0) begin
          $error("digest word %08h arrived with no word outstanding", m_tdata[31:0]);
          fail_count++;
        end else begin
          want = digest_due.pop_front();
          if (m_tdata[31:0] !== want.word) begin
            $error("digest_word expected %08h, got %08h", want.word, m_tdata[31:0]);
            fail_count++;
          end
          if (m_tdata[34:32] !== want.index) begin
            $error("word_index expected %0d, got %0d", want.index, m_tdata[34:32]);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_word expected %0b, got %0b", want.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
    words_due <= digest_due.size();
  end

endmodule

// ----- tb/sha256_stream_hasher_core_tb.sv -----
module sha256_stream_hasher_core_tb;

  // The receiver hold-off has to outlast a full message so that the core
  // backs up into its input; the stuck limit covers that plus two
  // compressions and a full padding pass with plenty of margin.
  localparam int HoldOffCycles = 400;
  localparam int StuckLimit    = 4000;
  localparam int SettleCycles  = 100;
  localparam int PhaseItems    = 16;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int words_due;

  // Idle rates in percent for the current phase, one for each side.
  int idle_pct  = 0;
  int stall_pct = 0;

  // The stimulus bumps hold_ticket to ask for one long receiver hold-off;
  // the receiver process serves it and counts the stall on its own.
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left   = 0;

  int stuck_cycles = 0;
  int phase_items  = 0;

  int idle_by_phase  [4] = '{0, 79, 0, 34};
  int stall_by_phase [4] = '{0, 0, 79, 34};

  sha256_stream_hasher_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sha256_digest_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side. A pending hold-off request takes priority over the
  // random stall pattern of the phase.
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HoldOffCycles;
      m_tready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: ends the run when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == StuckLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offers one item after a random number of idle cycles and returns once
  // it has been taken. Valid is only lowered when an idle cycle follows,
  // so back-to-back items keep it high without a glitch.
  task automatic send_item(input logic [7:0] data, input logic byte_ok, input logic ends);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= byte_ok;
    s_tlast  <= ends;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sends one message of the given length. The end is marked either on the
  // last byte or by a separate item without a byte; an empty message always
  // uses the separate item. Idle items are sprinkled in as noise.
  task automatic send_message(input int len);
    bit end_on_byte;
    end_on_byte = ($urandom_range(1) == 1) && (len > 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 10) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
      phase_items++;
    end
    if (!end_on_byte) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      phase_items++;
    end
  endtask

  // Stops offering items until every outstanding digest word has come back.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // Message lengths lean toward short messages and toward the padding
  // boundaries: 55 bytes still fits the length in one block, 56 through 63
  // need an extra block, and multiples of 64 close a block on a byte.
  function automatic int pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      return $urandom_range(8);
    end else if (roll < 65) begin
      case ($urandom_range(7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        default: return 128;
      endcase
    end
    return $urandom_range(80);
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty message, with a data byte that must be ignored.
    send_item(8'ha5, 1'b0, 1'b1);
    // "abc", ending on the last byte.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Idle items carrying junk, then the byte extremes and a separate end.
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hc3, 1'b0, 1'b1);
    // Single-byte messages at both extremes.
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct    = idle_by_phase[ph];
      stall_pct   = stall_by_phase[ph];
      phase_items = 0;
      // In the first phase the receiver stops for a long stretch while
      // short messages keep coming, so the core backs up into its input.
      if (ph == 0) begin
        hold_ticket <= hold_ticket + 1;
        for (int k = 0; k < 4; k++) send_message(2);
      end
      while (phase_items < PhaseItems) send_message(pick_length());
      wait_drain();
    end

    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_sched.sv
hw/rtl/sha256_round.sv
hw/rtl/sha256_stream_hasher_core.sv
tb/sha256_digest_checker.sv
tb/sha256_stream_hasher_core_tb.sv
